[design/slcp_pkg.sv]
// ----------------------------------------------------------------------------
// slcp_pkg
// Types and constants shared by the sound log command parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

  // width of the data block skip counter (16 to 32)
  localparam int unsigned SkipBits  = 32;
  // data block size field is four bytes; one spare byte above it for saturation
  localparam int unsigned SizeBytes = 4;
  localparam int unsigned SizeExtW  = SizeBytes * 8 + 8;

  typedef logic [SkipBits-1:0] skip_t;

  typedef enum logic [2:0] {
    PH_OPCODE = 3'd0,
    PH_GATHER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_MARK   = 3'd3,
    PH_TYPE   = 3'd4,
    PH_SIZE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_END   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // target chip indexes
  localparam logic [2:0] CHIP_YM3812  = 3'd0;
  localparam logic [2:0] CHIP_SN76489 = 3'd1;
  localparam logic [2:0] CHIP_YM2612  = 3'd2;
  localparam logic [2:0] CHIP_APU     = 3'd3;
  localparam logic [2:0] CHIP_DMG     = 3'd4;
  localparam logic [2:0] CHIP_POKEY   = 3'd5;

  // opcodes
  localparam logic [7:0] OP_SN_A       = 8'h4F;
  localparam logic [7:0] OP_SN_B       = 8'h50;
  localparam logic [7:0] OP_YM2612_P0  = 8'h52;
  localparam logic [7:0] OP_YM2612_P1  = 8'h53;
  localparam logic [7:0] OP_YM3812     = 8'h5A;
  localparam logic [7:0] OP_WAIT_N     = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC  = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL   = 8'h63;
  localparam logic [7:0] OP_END        = 8'h66;
  localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
  localparam logic [7:0] OP_DMG        = 8'hB3;
  localparam logic [7:0] OP_APU        = 8'hB4;
  localparam logic [7:0] OP_POKEY      = 8'hBB;
  localparam logic [7:0] DATA_MARKER   = 8'h66;

  localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

  localparam logic [5:0] CHIP_PRESENT_RST = 6'h3F;

endpackage

[design/sound_log_command_parser.sv]
// ----------------------------------------------------------------------------
// sound_log_command_parser
// Decodes a sound-chip register log command stream into chip writes and waits.
// ----------------------------------------------------------------------------
// One stream byte is taken per cycle and decoded in a single pass into the
// parser state and, when the byte completes a command, into the result
// register; a result appears on the output in the cycle after its last byte.
// The only back pressure is that one result register: in_stall_o is high
// while a result is held there and out_stall_i is high, so with an output
// that never stalls the block sustains one byte every cycle. Data block
// payloads and reserved operands are skipped at the same rate, one byte per
// cycle. After an end or error result all further bytes are taken and dropped
// until reset. cfg_we_i writes the chip present mask; writes to absent chips
// produce no item.
module sound_log_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [2:0]  chip_id_o,
  output logic        port_o,
  output logic [7:0]  reg_addr_o,
  output logic [7:0]  write_data_o,
  output logic [15:0] wait_samples_o
);

  localparam int unsigned SkipBits = slcp_pkg::SkipBits;
  localparam int unsigned ExtW     = slcp_pkg::SizeExtW;

  slcp_pkg::phase_e phase_q, phase_d;
  logic [7:0]       cur_op_q, cur_op_d;
  logic [2:0]       op_left_q, op_left_d;
  logic [7:0]       first_q, first_d;
  slcp_pkg::skip_t  skip_q, skip_d;
  logic             stopped_q, stopped_d;
  logic [5:0]       present_q;

  logic             out_valid_q;
  slcp_pkg::kind_e  kind_q;
  logic [2:0]       chip_q;
  logic             port_q;
  logic [7:0]       reg_q, data_q;
  logic [15:0]      wait_q;

  logic             in_acc;
  logic             res_emit;
  slcp_pkg::kind_e  res_kind;
  logic [2:0]       res_chip;
  logic             res_port;
  logic [7:0]       res_reg, res_data;
  logic [15:0]      res_wait;

  // operand gather helpers
  logic             wr_hit;
  logic [2:0]       wr_chip;
  logic             wr_port;
  logic [7:0]       wr_reg;
  logic [15:0]      wait_n;

  // size field assembly
  logic [2:0]       size_left;
  logic [1:0]       size_shift;
  logic [ExtW-1:0]  size_wide;
  slcp_pkg::skip_t  size_sat;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    size_left = op_left_q;
    if (op_left_q == 3'd0 || op_left_q > 3'd4) begin
      size_left = 3'd1;
    end
    size_shift = 2'(3'd4 - size_left);
    size_wide  = ExtW'(skip_q) | (ExtW'(stream_byte_i) << {size_shift, 3'b000});
    if (|size_wide[ExtW-1:SkipBits]) begin
      size_sat = '1;
    end else begin
      size_sat = size_wide[SkipBits-1:0];
    end
  end

  always_comb begin
    wr_hit  = 1'b1;
    wr_chip = slcp_pkg::CHIP_YM3812;
    wr_port = 1'b0;
    wr_reg  = first_q;
    wait_n  = {stream_byte_i, first_q};
    case (cur_op_q)
      slcp_pkg::OP_SN_A, slcp_pkg::OP_SN_B: begin
        wr_chip = slcp_pkg::CHIP_SN76489;
        wr_reg  = 8'd0;
      end
      slcp_pkg::OP_YM2612_P0: wr_chip = slcp_pkg::CHIP_YM2612;
      slcp_pkg::OP_YM2612_P1: begin
        wr_chip = slcp_pkg::CHIP_YM2612;
        wr_port = 1'b1;
      end
      slcp_pkg::OP_YM3812: wr_chip = slcp_pkg::CHIP_YM3812;
      slcp_pkg::OP_APU:    wr_chip = slcp_pkg::CHIP_APU;
      slcp_pkg::OP_DMG:    wr_chip = slcp_pkg::CHIP_DMG;
      slcp_pkg::OP_POKEY:  wr_chip = slcp_pkg::CHIP_POKEY;
      default:             wr_hit  = 1'b0;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    cur_op_d  = cur_op_q;
    op_left_d = op_left_q;
    first_d   = first_q;
    skip_d    = skip_q;
    stopped_d = stopped_q;
    res_emit  = 1'b0;
    res_kind  = slcp_pkg::KIND_WRITE;
    res_chip  = 3'd0;
    res_port  = 1'b0;
    res_reg   = 8'd0;
    res_data  = 8'd0;
    res_wait  = 16'd0;
    if (in_acc && !stopped_q) begin
      case (phase_q)
        slcp_pkg::PH_GATHER: begin
          if (op_left_q >= 3'd2) begin
            first_d   = stream_byte_i;
            op_left_d = 3'd1;
          end else begin
            op_left_d = 3'd0;
            phase_d   = slcp_pkg::PH_OPCODE;
            if (cur_op_q == slcp_pkg::OP_WAIT_N) begin
              res_kind = slcp_pkg::KIND_WAIT;
              res_wait = wait_n;
              res_emit = (wait_n != 16'd0);
            end else if (wr_hit) begin
              res_kind = slcp_pkg::KIND_WRITE;
              res_chip = wr_chip;
              res_port = wr_port;
              res_reg  = wr_reg;
              res_data = stream_byte_i;
              res_emit = present_q[wr_chip];
            end
          end
        end
        slcp_pkg::PH_SKIP: begin
          if (skip_q != '0) begin
            skip_d = skip_q - SkipBits'(1);
          end
          if (skip_d == '0) begin
            phase_d = slcp_pkg::PH_OPCODE;
          end
        end
        slcp_pkg::PH_MARK: begin
          if (stream_byte_i != slcp_pkg::DATA_MARKER) begin
            stopped_d = 1'b1;
            phase_d   = slcp_pkg::PH_OPCODE;
            res_kind  = slcp_pkg::KIND_ERROR;
            res_emit  = 1'b1;
          end else begin
            phase_d = slcp_pkg::PH_TYPE;
          end
        end
        slcp_pkg::PH_TYPE: begin
          op_left_d = 3'd4;
          skip_d    = '0;
          phase_d   = slcp_pkg::PH_SIZE;
        end
        slcp_pkg::PH_SIZE: begin
          skip_d    = size_sat;
          op_left_d = size_left - 3'd1;
          if (op_left_d == 3'd0) begin
            phase_d = (size_sat == '0) ? slcp_pkg::PH_OPCODE : slcp_pkg::PH_SKIP;
          end
        end
        default: begin
          cur_op_d = stream_byte_i;
          case (stream_byte_i) inside
            slcp_pkg::OP_SN_A, slcp_pkg::OP_SN_B: begin
              op_left_d = 3'd1;
              phase_d   = slcp_pkg::PH_GATHER;
            end
            slcp_pkg::OP_YM2612_P0, slcp_pkg::OP_YM2612_P1, slcp_pkg::OP_YM3812,
            slcp_pkg::OP_DMG, slcp_pkg::OP_APU, slcp_pkg::OP_POKEY,
            slcp_pkg::OP_WAIT_N: begin
              op_left_d = 3'd2;
              phase_d   = slcp_pkg::PH_GATHER;
            end
            slcp_pkg::OP_WAIT_NTSC: begin
              res_kind = slcp_pkg::KIND_WAIT;
              res_wait = slcp_pkg::WAIT_NTSC_SAMPLES;
              res_emit = 1'b1;
            end
            slcp_pkg::OP_WAIT_PAL: begin
              res_kind = slcp_pkg::KIND_WAIT;
              res_wait = slcp_pkg::WAIT_PAL_SAMPLES;
              res_emit = 1'b1;
            end
            slcp_pkg::OP_END: begin
              stopped_d = 1'b1;
              res_kind  = slcp_pkg::KIND_END;
              res_emit  = 1'b1;
            end
            slcp_pkg::OP_DATA_BLOCK: phase_d = slcp_pkg::PH_MARK;
            [8'h30:8'h3F]: begin
              skip_d  = SkipBits'(1);
              phase_d = slcp_pkg::PH_SKIP;
            end
            [8'h40:8'h4E], [8'hA1:8'hAF], [8'hBC:8'hBF]: begin
              skip_d  = SkipBits'(2);
              phase_d = slcp_pkg::PH_SKIP;
            end
            [8'hC5:8'hCF], [8'hD5:8'hDF]: begin
              skip_d  = SkipBits'(3);
              phase_d = slcp_pkg::PH_SKIP;
            end
            [8'hE0:8'hFF]: begin
              skip_d  = SkipBits'(4);
              phase_d = slcp_pkg::PH_SKIP;
            end
            // short waits: n+1 samples
            [8'h70:8'h7F]: begin
              res_kind = slcp_pkg::KIND_WAIT;
              res_wait = 16'(stream_byte_i[3:0]) + 16'd1;
              res_emit = 1'b1;
            end
            // short waits: n samples, none for zero
            [8'h80:8'h8F]: begin
              res_kind = slcp_pkg::KIND_WAIT;
              res_wait = 16'(stream_byte_i[3:0]);
              res_emit = (stream_byte_i[3:0] != 4'd0);
            end
            default: begin
              stopped_d = 1'b1;
              phase_d   = slcp_pkg::PH_OPCODE;
              res_kind  = slcp_pkg::KIND_ERROR;
              res_emit  = 1'b1;
            end
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= slcp_pkg::PH_OPCODE;
      cur_op_q    <= 8'd0;
      op_left_q   <= 3'd0;
      first_q     <= 8'd0;
      skip_q      <= '0;
      stopped_q   <= 1'b0;
      present_q   <= slcp_pkg::CHIP_PRESENT_RST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cur_op_q  <= cur_op_d;
      op_left_q <= op_left_d;
      first_q   <= first_d;
      skip_q    <= skip_d;
      stopped_q <= stopped_d;
      if (cfg_we_i) begin
        present_q <= cfg_wdata_i;
      end
      if (res_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_emit) begin
      kind_q <= res_kind;
      chip_q <= res_chip;
      port_q <= res_port;
      reg_q  <= res_reg;
      data_q <= res_data;
      wait_q <= res_wait;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign chip_id_o      = chip_q;
  assign port_o         = port_q;
  assign reg_addr_o     = reg_q;
  assign write_data_o   = data_q;
  assign wait_samples_o = wait_q;

  // an end or error item leaves the parser stopped
  a_stop_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == slcp_pkg::KIND_END || kind_q == slcp_pkg::KIND_ERROR)
    |-> stopped_q)
    else $error("end or error item without stopped parser");

  a_no_item_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !res_emit)
    else $error("item produced after stop");

  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == slcp_pkg::KIND_WAIT |-> wait_q != 16'd0)
    else $error("wait item with zero samples");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == slcp_pkg::PH_SKIP |-> skip_q != '0)
    else $error("skip phase with empty counter");

  a_held_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && !$past(res_emit))
    else $error("held item overwritten or dropped");

endmodule

[tb/tb_sound_log_command_parser.sv]
// ----------------------------------------------------------------------------
// tb_sound_log_command_parser
// Self-checking bench for the sound log command parser. A byte stream of
// well-formed commands with random operands is pushed through the block under
// several chip present masks. Each accepted byte is decoded by an independent
// predictor, and every result is checked field by field against the oldest
// predicted one. The run ends with a single end, undefined opcode or bad data
// block marker, followed by bytes that must be swallowed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sound_log_command_parser;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomBytes = 600;
  localparam int unsigned Phases      = 4;
  localparam int unsigned DrainCycles = 8;
  localparam longint unsigned SkipMax = (64'd1 << slcp_pkg::SkipBits) - 1;

  // reserved ranges whose operands are skipped
  localparam logic [7:0] OP_SKIP1_LO  = 8'h30;
  localparam logic [7:0] OP_SKIP1_HI  = 8'h3F;
  localparam logic [7:0] OP_SKIP2A_LO = 8'h40;
  localparam logic [7:0] OP_SKIP2A_HI = 8'h4E;
  localparam logic [7:0] OP_SKIP2B_LO = 8'hA1;
  localparam logic [7:0] OP_SKIP2B_HI = 8'hAF;
  localparam logic [7:0] OP_SKIP2C_LO = 8'hBC;
  localparam logic [7:0] OP_SKIP2C_HI = 8'hBF;
  localparam logic [7:0] OP_SKIP3A_LO = 8'hC5;
  localparam logic [7:0] OP_SKIP3A_HI = 8'hCF;
  localparam logic [7:0] OP_SKIP3B_LO = 8'hD5;
  localparam logic [7:0] OP_SKIP3B_HI = 8'hDF;
  localparam logic [7:0] OP_SKIP4_LO  = 8'hE0;
  localparam logic [7:0] OP_SKIP4_HI  = 8'hFF;
  // packed short waits, low nibble carries the count
  localparam logic [7:0] OP_WAIT_PLUS1 = 8'h70;
  localparam logic [7:0] OP_WAIT_NIB   = 8'h80;
  localparam logic [7:0] NIB_MASK      = 8'hF0;

  typedef enum logic [1:0] {
    STOP_END,
    STOP_UNDEF,
    STOP_BAD_MARK
  } stop_e;

  typedef struct packed {
    slcp_pkg::kind_e kind;
    logic [2:0]      chip_id;
    logic            port;
    logic [7:0]      reg_addr;
    logic [7:0]      write_data;
    logic [15:0]     wait_samples;
  } log_event_t;

  class log_event_board;
    logic [5:0]       present;
    slcp_pkg::phase_e phase;
    logic [7:0]       cur_op;
    logic [2:0]       ops_left;
    logic [7:0]       first_op;
    slcp_pkg::skip_t  skip_left;
    bit               stopped;
    log_event_t       pending[$];
    int unsigned      mismatches;
    int unsigned      checked;

    function new();
      present    = slcp_pkg::CHIP_PRESENT_RST;
      phase      = slcp_pkg::PH_OPCODE;
      cur_op     = '0;
      ops_left   = '0;
      first_op   = '0;
      skip_left  = '0;
      stopped    = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void post(slcp_pkg::kind_e k, logic [2:0] chip, logic prt, logic [7:0] ra,
                       logic [7:0] wd, logic [15:0] ws);
      pending.push_back(log_event_t'{k, chip, prt, ra, wd, ws});
    endfunction

    function void chip_write(logic [2:0] chip, logic prt, logic [7:0] ra, logic [7:0] wd);
      if (present[chip]) post(slcp_pkg::KIND_WRITE, chip, prt, ra, wd, '0);
    endfunction

    function void post_wait(logic [15:0] n);
      if (n != 0) post(slcp_pkg::KIND_WAIT, '0, 1'b0, '0, '0, n);
    endfunction

    function void halt(slcp_pkg::kind_e k);
      stopped = 1'b1;
      phase   = slcp_pkg::PH_OPCODE;
      post(k, '0, 1'b0, '0, '0, '0);
    endfunction

    function void start_skip(slcp_pkg::skip_t n);
      skip_left = n;
      phase     = slcp_pkg::PH_SKIP;
    endfunction

    function void complete(logic [7:0] b);
      phase = slcp_pkg::PH_OPCODE;
      case (cur_op)
        slcp_pkg::OP_SN_A, slcp_pkg::OP_SN_B:
          chip_write(slcp_pkg::CHIP_SN76489, 1'b0, '0, b);
        slcp_pkg::OP_YM2612_P0: chip_write(slcp_pkg::CHIP_YM2612, 1'b0, first_op, b);
        slcp_pkg::OP_YM2612_P1: chip_write(slcp_pkg::CHIP_YM2612, 1'b1, first_op, b);
        slcp_pkg::OP_YM3812:    chip_write(slcp_pkg::CHIP_YM3812, 1'b0, first_op, b);
        slcp_pkg::OP_APU:       chip_write(slcp_pkg::CHIP_APU, 1'b0, first_op, b);
        slcp_pkg::OP_DMG:       chip_write(slcp_pkg::CHIP_DMG, 1'b0, first_op, b);
        slcp_pkg::OP_POKEY:     chip_write(slcp_pkg::CHIP_POKEY, 1'b0, first_op, b);
        slcp_pkg::OP_WAIT_N:    post_wait({b, first_op});
        default: ;
      endcase
    endfunction

    function void decode(logic [7:0] op);
      cur_op = op;
      case (op)
        slcp_pkg::OP_SN_A, slcp_pkg::OP_SN_B: begin
          ops_left = 3'd1;
          phase    = slcp_pkg::PH_GATHER;
        end
        slcp_pkg::OP_YM2612_P0, slcp_pkg::OP_YM2612_P1, slcp_pkg::OP_YM3812,
        slcp_pkg::OP_DMG, slcp_pkg::OP_APU, slcp_pkg::OP_POKEY,
        slcp_pkg::OP_WAIT_N: begin
          ops_left = 3'd2;
          phase    = slcp_pkg::PH_GATHER;
        end
        slcp_pkg::OP_WAIT_NTSC:  post_wait(slcp_pkg::WAIT_NTSC_SAMPLES);
        slcp_pkg::OP_WAIT_PAL:   post_wait(slcp_pkg::WAIT_PAL_SAMPLES);
        slcp_pkg::OP_END:        halt(slcp_pkg::KIND_END);
        slcp_pkg::OP_DATA_BLOCK: phase = slcp_pkg::PH_MARK;
        default: begin
          if (op >= OP_SKIP1_LO && op <= OP_SKIP1_HI) start_skip(slcp_pkg::skip_t'(1));
          else if ((op >= OP_SKIP2A_LO && op <= OP_SKIP2A_HI) ||
                   (op >= OP_SKIP2B_LO && op <= OP_SKIP2B_HI) ||
                   (op >= OP_SKIP2C_LO && op <= OP_SKIP2C_HI))
            start_skip(slcp_pkg::skip_t'(2));
          else if ((op >= OP_SKIP3A_LO && op <= OP_SKIP3A_HI) ||
                   (op >= OP_SKIP3B_LO && op <= OP_SKIP3B_HI))
            start_skip(slcp_pkg::skip_t'(3));
          else if (op >= OP_SKIP4_LO) start_skip(slcp_pkg::skip_t'(4));
          else if ((op & NIB_MASK) == OP_WAIT_PLUS1) post_wait(16'(op[3:0]) + 16'd1);
          else if ((op & NIB_MASK) == OP_WAIT_NIB) post_wait(16'(op[3:0]));
          else halt(slcp_pkg::KIND_ERROR);
        end
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      logic [2:0]      left;
      int unsigned     shift;
      longint unsigned v;
      if (stopped) return;
      case (phase)
        slcp_pkg::PH_GATHER: begin
          if (ops_left >= 3'd2) begin
            first_op = b;
            ops_left = 3'd1;
          end else begin
            ops_left = 3'd0;
            complete(b);
          end
        end
        slcp_pkg::PH_SKIP: begin
          if (skip_left != 0) skip_left = skip_left - 1'b1;
          if (skip_left == 0) phase = slcp_pkg::PH_OPCODE;
        end
        slcp_pkg::PH_MARK: begin
          if (b != slcp_pkg::DATA_MARKER) halt(slcp_pkg::KIND_ERROR);
          else phase = slcp_pkg::PH_TYPE;
        end
        slcp_pkg::PH_TYPE: begin
          ops_left  = 3'd4;
          skip_left = '0;
          phase     = slcp_pkg::PH_SIZE;
        end
        slcp_pkg::PH_SIZE: begin
          left = ops_left;
          if (left == 0 || left > 3'd4) left = 3'd1;
          shift = (4 - left) * 8;
          // size is little-endian, saturating at the counter width
          v = 64'(skip_left) | (64'(b) << shift);
          if (v > SkipMax) v = SkipMax;
          skip_left = slcp_pkg::skip_t'(v);
          ops_left  = left - 3'd1;
          if (ops_left == 0)
            phase = (skip_left == 0) ? slcp_pkg::PH_OPCODE : slcp_pkg::PH_SKIP;
        end
        default: decode(b);
      endcase
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void match_result(log_event_t got);
      log_event_t want;
      if (pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none actual kind %0d chip %0d",
                 $time, got.kind, got.chip_id);
        return;
      end
      want = pending.pop_front();
      checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("chip_id", want.chip_id, got.chip_id);
      compare_field("port", want.port, got.port);
      compare_field("reg_addr", want.reg_addr, got.reg_addr);
      compare_field("write_data", want.write_data, got.write_data);
      compare_field("wait_samples", want.wait_samples, got.wait_samples);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [2:0]  chip_id;
  logic        port;
  logic [7:0]  reg_addr;
  logic [7:0]  write_data;
  logic [15:0] wait_samples;

  log_event_board board = new();
  int unsigned    sent_bytes;
  int unsigned    burst_left;
  int unsigned    mask_writes;
  int unsigned    idle_cycles;
  bit             hold_req;
  bit             hold_done;
  stop_e          stop_kind;

  sound_log_command_parser u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .stream_byte_i  (stream_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .chip_id_o      (chip_id),
    .port_o         (port),
    .reg_addr_o     (reg_addr),
    .write_data_o   (write_data),
    .wait_samples_o (wait_samples)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] write_op(int unsigned i);
    case (i)
      0:       return slcp_pkg::OP_SN_A;
      1:       return slcp_pkg::OP_SN_B;
      2:       return slcp_pkg::OP_YM2612_P0;
      3:       return slcp_pkg::OP_YM2612_P1;
      4:       return slcp_pkg::OP_YM3812;
      5:       return slcp_pkg::OP_DMG;
      6:       return slcp_pkg::OP_APU;
      default: return slcp_pkg::OP_POKEY;
    endcase
  endfunction

  // opcodes with no defined meaning, spread over the undefined ranges
  function automatic logic [7:0] undef_op(int unsigned i);
    case (i)
      0:       return 8'h00;
      1:       return 8'h2F;
      2:       return 8'h51;
      3:       return 8'h64;
      4:       return 8'h6F;
      5:       return 8'h90;
      6:       return 8'hB0;
      default: return 8'hD4;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid    <= 1'b1;
    stream_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(b);
    sent_bytes++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_mask(input logic [5:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.present = m;
    mask_writes++;
  endtask

  task automatic send_command();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  op;
    logic [15:0] size;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      op = write_op($urandom_range(0, 7));
      send_byte(op);
      if (op != slcp_pkg::OP_SN_A && op != slcp_pkg::OP_SN_B)
        send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 52) begin
      send_byte(slcp_pkg::OP_WAIT_N);
      if ($urandom_range(0, 7) == 0) begin
        send_byte(8'h00);
        send_byte(8'h00);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end
    end else if (pick < 60) begin
      send_byte($urandom_range(0, 1) ? slcp_pkg::OP_WAIT_NTSC : slcp_pkg::OP_WAIT_PAL);
    end else if (pick < 72) begin
      op = $urandom_range(0, 1) ? OP_WAIT_PLUS1 : OP_WAIT_NIB;
      send_byte(op | 8'($urandom_range(0, 15)));
    end else if (pick < 90) begin
      // reserved opcode with junk operands, often looking like opcodes
      case ($urandom_range(0, 5))
        0: begin op = 8'($urandom_range(OP_SKIP1_LO, OP_SKIP1_HI)); n = 1; end
        1: begin op = 8'($urandom_range(OP_SKIP2A_LO, OP_SKIP2A_HI)); n = 2; end
        2: begin op = 8'($urandom_range(OP_SKIP2B_LO, OP_SKIP2B_HI)); n = 2; end
        3: begin op = 8'($urandom_range(OP_SKIP2C_LO, OP_SKIP2C_HI)); n = 2; end
        4: begin
          op = $urandom_range(0, 1) ? 8'($urandom_range(OP_SKIP3A_LO, OP_SKIP3A_HI))
                                    : 8'($urandom_range(OP_SKIP3B_LO, OP_SKIP3B_HI));
          n = 3;
        end
        default: begin op = 8'($urandom_range(OP_SKIP4_LO, OP_SKIP4_HI)); n = 4; end
      endcase
      send_byte(op);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 19))
        0:       size = 16'd0;
        1:       size = 16'($urandom_range(256, 300));
        default: size = 16'($urandom_range(1, 24));
      endcase
      send_byte(slcp_pkg::OP_DATA_BLOCK);
      send_byte(slcp_pkg::DATA_MARKER);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(size[7:0]);
      send_byte(size[15:8]);
      send_byte(8'h00);
      send_byte(8'h00);
      repeat (size) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.match_result(log_event_t'{slcp_pkg::kind_e'(kind), chip_id, port, reg_addr,
                                      write_data, wait_samples});
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // output side stall patterns, with one long hold on request
  initial begin : receiver
    int unsigned mode;
    int unsigned len;
    int unsigned cyc;
    out_stall <= 1'b0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(16, 96);
      repeat (len) begin
        @(posedge clk);
        cyc++;
        if (hold_req && !hold_done) begin
          out_stall <= 1'b1;
          repeat (HoldCycles) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  b;
    logic [5:0]  m;
    int unsigned phase_end;
    in_valid    <= 1'b0;
    stream_byte <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    sent_bytes  = 0;
    burst_left  = 0;
    mask_writes = 0;
    hold_req    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, under the reset mask
    send_byte(slcp_pkg::OP_YM3812);  send_byte(8'h00); send_byte(8'hFF);
    send_byte(slcp_pkg::OP_YM2612_P1); send_byte(8'hFF); send_byte(8'h00);
    send_byte(slcp_pkg::OP_SN_A);    send_byte(8'hA5);
    // zero count, no item
    send_byte(slcp_pkg::OP_WAIT_N);  send_byte(8'h00); send_byte(8'h00);
    send_byte(slcp_pkg::OP_WAIT_N);  send_byte(8'hFF); send_byte(8'hFF);
    send_byte(slcp_pkg::OP_WAIT_NTSC);
    send_byte(slcp_pkg::OP_WAIT_PAL);
    send_byte(OP_WAIT_PLUS1 | 8'h0F);
    send_byte(OP_WAIT_NIB);                                  // zero count, no item
    send_byte(OP_WAIT_NIB | 8'h0F);
    // bank operand holding end and data block codes must be skipped
    send_byte(OP_SKIP4_LO); send_byte(slcp_pkg::OP_END); send_byte(slcp_pkg::OP_DATA_BLOCK);
    send_byte(8'h00); send_byte(8'hFF);
    // empty data block
    send_byte(slcp_pkg::OP_DATA_BLOCK); send_byte(slcp_pkg::DATA_MARKER); send_byte(8'h01);
    repeat (4) send_byte(8'h00);
    settle();

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0:       m = 6'h00;
        1:       m = slcp_pkg::CHIP_PRESENT_RST;
        2:       m = 6'($urandom_range(1, 62));
        default: m = 6'($urandom_range(0, 63));
      endcase
      write_mask(m);
      if (p == 1) hold_req = 1'b1;
      phase_end = sent_bytes + RandomBytes / Phases;
      while (sent_bytes < phase_end) send_command();
      settle();
    end

    stop_kind = stop_e'($urandom_range(0, 2));
    case (stop_kind)
      STOP_END:   send_byte(slcp_pkg::OP_END);
      STOP_UNDEF: send_byte(undef_op($urandom_range(0, 7)));
      default: begin
        send_byte(slcp_pkg::OP_DATA_BLOCK);
        do b = 8'($urandom_range(0, 255)); while (b == slcp_pkg::DATA_MARKER);
        send_byte(b);
      end
    endcase
    // after stopping, everything is swallowed
    send_byte(slcp_pkg::OP_WAIT_NTSC);
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    settle();

    $display("summary: %0d bytes, %0d results checked, %0d mask settings",
             sent_bytes, board.checked, mask_writes);
    $display("summary: stream closed by %s, long output hold %s",
             stop_kind.name(), hold_done ? "done" : "missed");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
